// ===== rtl/core/card_detect_test_sequencer_defines.svh =====
// Assertion macros for the card detect test sequencer.
`ifndef CARD_DETECT_TEST_SEQUENCER_DEFINES_SVH
`define CARD_DETECT_TEST_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only while reset is low.
`define CDTS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("cdts assertion failed");
// Checked at every edge, reset included.
`define CDTS_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("cdts assertion failed");
`else
`define CDTS_ASSERT(lbl, prop)
`define CDTS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/core/cdts_pkg.sv =====
`timescale 1ns / 1ps

package cdts_pkg;

   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTINUOUS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPOLL_DELAY  = 2'd2;

   localparam logic [31:0] MIN_RETRY_MS       = 32'd10;
   localparam logic [3:0]  MAX_TRIES          = 4'd3;
   localparam logic [3:0]  EXPECTED_CARDS     = 4'd1;
   localparam logic [31:0] DEFAULT_TIMEOUT_MS = 32'd10000;

   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_POLL     = 3'd1,
      PH_RETRY    = 3'd2,
      PH_ANTICOL  = 3'd3,
      PH_DETECTED = 3'd4,
      PH_TIMEOUT  = 3'd5,
      PH_RESET    = 3'd6,
      PH_DELAY    = 3'd7
   } phase_type;

   // effective configuration seen by the step logic
   typedef struct packed {
      logic [31:0] limit_ms;
      logic        continuous;
      logic [31:0] delay_ms;
   } cfg_type;

   typedef struct packed {
      logic        op;
      logic [31:0] now_ms;
      logic        poll_ok;
      logic        setup_ok;
      logic        resolve_ok;
      logic [3:0]  cards_found;
   } item_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] test_start_ms;
      logic [31:0] test_end_ms;
      logic [31:0] delay_start_ms;
      logic [31:0] delay_end_ms;
      logic [3:0]  resolve_tries;
   } state_type;

   typedef struct packed {
      phase_type phase_now;
      logic      detected_event;
      logic      timeout_event;
      logic      field_off;
      logic      restore_mode;
   } result_type;

endpackage

// ===== rtl/core/cdts_csr.sv =====
`timescale 1ns / 1ps

module cdts_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cdts_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                       csr_data,
   output cdts_pkg::cfg_type                 cfg
);
   import cdts_pkg::*;

   logic [31:0] limit_ff;
   logic        continuous_ff;
   logic [31:0] delay_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= '0;
         continuous_ff <= 1'b0;
         delay_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TIMEOUT_LIMIT: limit_ff      <= csr_data;
            CSR_CONTINUOUS:    continuous_ff <= csr_data[0];
            CSR_REPOLL_DELAY:  delay_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.limit_ms   = (limit_ff == '0) ? DEFAULT_TIMEOUT_MS : limit_ff;
      cfg.continuous = continuous_ff;
      cfg.delay_ms   = (delay_ff != '0 && delay_ff < MIN_RETRY_MS) ? MIN_RETRY_MS : delay_ff;
   end

endmodule

// ===== rtl/core/cdts_step.sv =====
`timescale 1ns / 1ps

module cdts_step (
   input  cdts_pkg::item_type   item,
   input  cdts_pkg::state_type  state,
   input  cdts_pkg::cfg_type    cfg,
   output cdts_pkg::state_type  state_next,
   output cdts_pkg::result_type res
);
   import cdts_pkg::*;

   logic       expired;
   logic       delay_done;
   logic [3:0] tries_inc;

   assign expired    = (item.now_ms < state.test_start_ms) ||
                       (item.now_ms >= state.test_end_ms);
   assign delay_done = (item.now_ms < state.delay_start_ms) ||
                       (item.now_ms >= state.delay_end_ms);
   assign tries_inc  = state.resolve_tries + 4'd1;

   always_comb begin
      state_next         = state;
      res.detected_event = 1'b0;
      res.timeout_event  = 1'b0;
      res.field_off      = 1'b0;
      res.restore_mode   = 1'b0;
      if (item.op == OP_BEGIN) begin
         state_next.phase         = PH_POLL;
         state_next.test_start_ms = item.now_ms;
         state_next.test_end_ms   = item.now_ms + cfg.limit_ms;
         state_next.resolve_tries = '0;
      end else begin
         case (state.phase)
            PH_POLL: begin
               if (expired) begin
                  res.field_off    = 1'b1;
                  state_next.phase = PH_TIMEOUT;
               end else if (item.poll_ok) begin
                  state_next.phase         = PH_ANTICOL;
                  state_next.resolve_tries = '0;
               end else begin
                  state_next.phase = PH_RETRY;
               end
            end
            PH_RETRY: begin
               res.field_off    = 1'b1;
               state_next.phase = expired ? PH_TIMEOUT : PH_POLL;
            end
            PH_ANTICOL: begin
               if (state.resolve_tries == '0 && !item.setup_ok) begin
                  state_next.phase = PH_RETRY;
               end else if (item.resolve_ok && item.cards_found == EXPECTED_CARDS) begin
                  res.field_off            = 1'b1;
                  state_next.phase         = PH_DETECTED;
                  state_next.resolve_tries = '0;
               end else if (tries_inc >= MAX_TRIES || tries_inc == '0) begin
                  res.field_off            = 1'b1;
                  state_next.phase         = PH_RETRY;
                  state_next.resolve_tries = '0;
               end else begin
                  state_next.resolve_tries = tries_inc;
               end
            end
            PH_DETECTED: begin
               res.detected_event = 1'b1;
               if (!cfg.continuous) begin
                  state_next.phase = PH_RESET;
               end else if (cfg.delay_ms != '0) begin
                  res.field_off             = 1'b1;
                  state_next.delay_start_ms = item.now_ms;
                  state_next.delay_end_ms   = item.now_ms + cfg.delay_ms;
                  state_next.phase          = PH_DELAY;
               end else begin
                  state_next.phase = PH_RETRY;
               end
            end
            PH_DELAY: begin
               if (expired) begin
                  state_next.phase = PH_TIMEOUT;
               end else if (delay_done) begin
                  state_next.phase = PH_POLL;
               end
            end
            PH_TIMEOUT: begin
               res.timeout_event = 1'b1;
               state_next.phase  = PH_RESET;
            end
            PH_RESET: begin
               res.field_off    = 1'b1;
               res.restore_mode = 1'b1;
               state_next.phase = PH_IDLE;
            end
            default: ;
         endcase
      end
      res.phase_now = state_next.phase;
   end

endmodule

// ===== rtl/core/card_detect_test_sequencer.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | op, now_ms, poll_ok, setup_ok, resolve_ok, cards_found
// rsp     | out       | rsp_valid/rsp_stall | phase_now, detected/timeout events, field_off, restore_mode
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// An item goes via the input and result registers; one item per cycle while rsp_stall is low.
// Rate set by the combinational step logic between the input and result registers.
// Sequencer state commits when an item moves from the input to the result register.
// A stalled rsp holds the result; the input register still takes one more item.
// Synchronous reset returns to idle and clears the configuration; csr_ready is always high.

module card_detect_test_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_op,
   input  logic [31:0]                      req_now_ms,
   input  logic                             req_poll_ok,
   input  logic                             req_setup_ok,
   input  logic                             req_resolve_ok,
   input  logic [3:0]                       req_cards_found,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_phase_now,
   output logic                             rsp_detected_event,
   output logic                             rsp_timeout_event,
   output logic                             rsp_field_off,
   output logic                             rsp_restore_mode,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cdts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_data
);
   import cdts_pkg::*;

`include "card_detect_test_sequencer_defines.svh"

   cfg_type    cfg;
   item_type   s1_item_ff;
   logic       s1_valid_ff;
   logic       s2_valid_ff;
   result_type s2_res_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type res;
   logic       s2_free;
   logic       s1_move;
   logic       s1_load;

   cdts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cdts_step u_step (
      .item       (s1_item_ff),
      .state      (state_ff),
      .cfg        (cfg),
      .state_next (state_in),
      .res        (res)
   );

   assign s2_free   = !s2_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;
   assign s1_load   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff             <= 1'b0;
         s2_valid_ff             <= 1'b0;
         state_ff.phase          <= PH_IDLE;
         state_ff.test_start_ms  <= '0;
         state_ff.test_end_ms    <= '0;
         state_ff.delay_start_ms <= '0;
         state_ff.delay_end_ms   <= '0;
         state_ff.resolve_tries  <= '0;
      end else begin
         if (s1_load || s1_move) begin
            s1_valid_ff <= s1_load;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_move;
         end
         if (s1_move) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_item_ff.op          <= req_op;
         s1_item_ff.now_ms      <= req_now_ms;
         s1_item_ff.poll_ok     <= req_poll_ok;
         s1_item_ff.setup_ok    <= req_setup_ok;
         s1_item_ff.resolve_ok  <= req_resolve_ok;
         s1_item_ff.cards_found <= req_cards_found;
      end
      if (s1_move) begin
         s2_res_ff <= res;
      end
   end

   assign rsp_valid          = s2_valid_ff;
   assign rsp_phase_now      = s2_res_ff.phase_now;
   assign rsp_detected_event = s2_res_ff.detected_event;
   assign rsp_timeout_event  = s2_res_ff.timeout_event;
   assign rsp_field_off      = s2_res_ff.field_off;
   assign rsp_restore_mode   = s2_res_ff.restore_mode;

   `CDTS_ASSERT(a_move_fills_rsp, s1_move |=> s2_valid_ff)
   `CDTS_ASSERT(a_held_item_stable, req_stall |=> s1_valid_ff && $stable(s1_item_ff))
   `CDTS_ASSERT(a_state_holds, !s1_move |=> $stable(state_ff.phase))
   `CDTS_ASSERT(a_timeout_to_reset, s1_move && res.timeout_event |=> state_ff.phase == PH_RESET)
   `CDTS_ASSERT_ALWAYS(a_stall_needs_item, req_stall |-> s1_valid_ff)

endmodule

// ===== bench/card_detect_test_sequencer_checker.sv =====
`timescale 1ns / 1ps

module card_detect_test_sequencer_checker
   import cdts_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic                    req_op,
   input  logic [31:0]             req_now_ms,
   input  logic                    req_poll_ok,
   input  logic                    req_setup_ok,
   input  logic                    req_resolve_ok,
   input  logic [3:0]              req_cards_found,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [2:0]              rsp_phase_now,
   input  logic                    rsp_detected_event,
   input  logic                    rsp_timeout_event,
   input  logic                    rsp_field_off,
   input  logic                    rsp_restore_mode,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]             csr_data,
   output int                      fail_count,
   output int                      pending_results,
   output int                      live_items,
   output int                      results_seen,
   output int                      detections,
   output int                      timeouts
);

   cfg_type    cfg_regs;
   state_type  seq_state;
   result_type step_results_q[$];
   int         fail_n;
   int         live_n;
   int         seen_n;
   int         det_n;
   int         tmo_n;

   initial begin
      fail_n = 0;
      live_n = 0;
      seen_n = 0;
      det_n  = 0;
      tmo_n  = 0;
   end

   function automatic logic test_expired(logic [31:0] now);
      return (now < seq_state.test_start_ms) || (now >= seq_state.test_end_ms);
   endfunction

   function automatic result_type advance_sequencer(item_type it);
      result_type  r;
      logic [31:0] lim;
      logic [31:0] dly;
      r = '0;
      if (it.op == OP_BEGIN) begin
         lim = (cfg_regs.limit_ms != 32'd0) ? cfg_regs.limit_ms : DEFAULT_TIMEOUT_MS;
         seq_state.phase         = PH_POLL;
         seq_state.test_start_ms = it.now_ms;
         seq_state.test_end_ms   = it.now_ms + lim;
         seq_state.resolve_tries = 4'd0;
      end else begin
         case (seq_state.phase)
            PH_POLL: begin
               if (test_expired(it.now_ms)) begin
                  r.field_off     = 1'b1;
                  seq_state.phase = PH_TIMEOUT;
               end else if (it.poll_ok) begin
                  seq_state.phase         = PH_ANTICOL;
                  seq_state.resolve_tries = 4'd0;
               end else begin
                  seq_state.phase = PH_RETRY;
               end
            end
            PH_RETRY: begin
               r.field_off = 1'b1;
               if (test_expired(it.now_ms)) seq_state.phase = PH_TIMEOUT;
               else seq_state.phase = PH_POLL;
            end
            PH_ANTICOL: begin
               if (seq_state.resolve_tries == 4'd0 && !it.setup_ok) begin
                  seq_state.phase = PH_RETRY;
               end else if (it.resolve_ok && it.cards_found == EXPECTED_CARDS) begin
                  r.field_off             = 1'b1;
                  seq_state.phase         = PH_DETECTED;
                  seq_state.resolve_tries = 4'd0;
               end else begin
                  seq_state.resolve_tries = seq_state.resolve_tries + 4'd1;
                  if (seq_state.resolve_tries >= MAX_TRIES || seq_state.resolve_tries == 4'd0) begin
                     r.field_off             = 1'b1;
                     seq_state.phase         = PH_RETRY;
                     seq_state.resolve_tries = 4'd0;
                  end
               end
            end
            PH_DETECTED: begin
               r.detected_event = 1'b1;
               if (cfg_regs.continuous) begin
                  dly = cfg_regs.delay_ms;
                  if (dly != 32'd0 && dly < MIN_RETRY_MS) dly = MIN_RETRY_MS;
                  if (dly != 32'd0) begin
                     r.field_off              = 1'b1;
                     seq_state.delay_start_ms = it.now_ms;
                     seq_state.delay_end_ms   = it.now_ms + dly;
                     seq_state.phase          = PH_DELAY;
                  end else begin
                     seq_state.phase = PH_RETRY;
                  end
               end else begin
                  seq_state.phase = PH_RESET;
               end
            end
            PH_DELAY: begin
               if (test_expired(it.now_ms)) begin
                  seq_state.phase = PH_TIMEOUT;
               end else if (it.now_ms < seq_state.delay_start_ms ||
                            it.now_ms >= seq_state.delay_end_ms) begin
                  seq_state.phase = PH_POLL;
               end
            end
            PH_TIMEOUT: begin
               r.timeout_event = 1'b1;
               seq_state.phase = PH_RESET;
            end
            PH_RESET: begin
               r.field_off     = 1'b1;
               r.restore_mode  = 1'b1;
               seq_state.phase = PH_IDLE;
            end
            default: ;
         endcase
      end
      r.phase_now = seq_state.phase;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      item_type   it;
      result_type want;
      if (reset) begin
         cfg_regs  = '0;
         seq_state = '0;
         step_results_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TIMEOUT_LIMIT: cfg_regs.limit_ms   = csr_data;
               CSR_CONTINUOUS:    cfg_regs.continuous = csr_data[0];
               CSR_REPOLL_DELAY:  cfg_regs.delay_ms   = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (step_results_q.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_n++;
            end else begin
               want = step_results_q.pop_front();
               seen_n++;
               if (want.detected_event) det_n++;
               if (want.timeout_event) tmo_n++;
               if (want.phase_now !== rsp_phase_now) begin
                  $error("phase_now: expected %0d, got %0d", want.phase_now, rsp_phase_now);
                  fail_n++;
               end
               if (want.detected_event !== rsp_detected_event) begin
                  $error("detected_event: expected %0d, got %0d",
                         want.detected_event, rsp_detected_event);
                  fail_n++;
               end
               if (want.timeout_event !== rsp_timeout_event) begin
                  $error("timeout_event: expected %0d, got %0d",
                         want.timeout_event, rsp_timeout_event);
                  fail_n++;
               end
               if (want.field_off !== rsp_field_off) begin
                  $error("field_off: expected %0d, got %0d", want.field_off, rsp_field_off);
                  fail_n++;
               end
               if (want.restore_mode !== rsp_restore_mode) begin
                  $error("restore_mode: expected %0d, got %0d",
                         want.restore_mode, rsp_restore_mode);
                  fail_n++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            it.op          = req_op;
            it.now_ms      = req_now_ms;
            it.poll_ok     = req_poll_ok;
            it.setup_ok    = req_setup_ok;
            it.resolve_ok  = req_resolve_ok;
            it.cards_found = req_cards_found;
            // a step in idle is ignored by the block
            if (it.op == OP_BEGIN || seq_state.phase != PH_IDLE) live_n++;
            step_results_q.push_back(advance_sequencer(it));
         end
      end
      fail_count      <= fail_n;
      pending_results <= step_results_q.size();
      live_items      <= live_n;
      results_seen    <= seen_n;
      detections      <= det_n;
      timeouts        <= tmo_n;
   end

endmodule

// ===== bench/card_detect_test_sequencer_tb.sv =====
`timescale 1ns / 1ps

module card_detect_test_sequencer_tb;
   import cdts_pkg::*;

   localparam int STALL_LIMIT   = 3000;
   localparam int PRESSURE_HOLD = 400;
   localparam int PHASE_ITEMS   = 150;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_op;
   logic [31:0]            req_now_ms;
   logic                   req_poll_ok;
   logic                   req_setup_ok;
   logic                   req_resolve_ok;
   logic [3:0]             req_cards_found;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [2:0]             rsp_phase_now;
   logic                   rsp_detected_event;
   logic                   rsp_timeout_event;
   logic                   rsp_field_off;
   logic                   rsp_restore_mode;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_data;

   int fail_count;
   int pending_results;
   int live_items;
   int results_seen;
   int detections;
   int timeouts;

   logic        pressure_go;
   logic        pressure_done;
   logic        sender_idles;
   logic [31:0] clock_ms;
   int          items_sent;
   int          settings_run;

   card_detect_test_sequencer DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_now_ms         (req_now_ms),
      .req_poll_ok        (req_poll_ok),
      .req_setup_ok       (req_setup_ok),
      .req_resolve_ok     (req_resolve_ok),
      .req_cards_found    (req_cards_found),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_phase_now      (rsp_phase_now),
      .rsp_detected_event (rsp_detected_event),
      .rsp_timeout_event  (rsp_timeout_event),
      .rsp_field_off      (rsp_field_off),
      .rsp_restore_mode   (rsp_restore_mode),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   card_detect_test_sequencer_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_now_ms         (req_now_ms),
      .req_poll_ok        (req_poll_ok),
      .req_setup_ok       (req_setup_ok),
      .req_resolve_ok     (req_resolve_ok),
      .req_cards_found    (req_cards_found),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_phase_now      (rsp_phase_now),
      .rsp_detected_event (rsp_detected_event),
      .rsp_timeout_event  (rsp_timeout_event),
      .rsp_field_off      (rsp_field_off),
      .rsp_restore_mode   (rsp_restore_mode),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .pending_results    (pending_results),
      .live_items         (live_items),
      .results_seen       (results_seen),
      .detections         (detections),
      .timeouts           (timeouts)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("card_detect_test_sequencer verification failed");
            $finish;
         end
      end
   end

   initial begin : receiver
      int stall_len;
      int open_len;
      pressure_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         if (pressure_go && !pressure_done) begin
            // wait for the sender to offer, then hold long so the pipeline fills
            @(posedge clock);
            while (!req_valid) @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (PRESSURE_HOLD) @(posedge clock);
            pressure_done = 1'b1;
         end
         stall_len = pick_gap();
         open_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (open_len) @(posedge clock);
      end
   end

   task automatic send_item(logic op, logic [31:0] now, logic poll, logic setup,
                            logic resolve, logic [3:0] cards);
      int gap;
      gap = sender_idles ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_now_ms      <= now;
      req_poll_ok     <= poll;
      req_setup_ok    <= setup;
      req_resolve_ok  <= resolve;
      req_cards_found <= cards;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic step_at(logic [31:0] now, logic poll, logic setup, logic resolve,
                          logic [3:0] cards);
      send_item(OP_STEP, now, poll, setup, resolve, cards);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_config(logic [31:0] lim, logic cont, logic [31:0] dly);
      drain_results();
      write_csr(CSR_TIMEOUT_LIMIT, lim);
      write_csr(CSR_CONTINUOUS, {31'd0, cont});
      write_csr(CSR_REPOLL_DELAY, dly);
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   task automatic advance_clock();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) clock_ms = clock_ms + $urandom_range(0, 3);
      else if (r < 92) clock_ms = clock_ms + $urandom_range(0, 60);
      else if (r < 96) clock_ms = clock_ms + $urandom_range(0, 12000);
      else if (r < 98) clock_ms = clock_ms - $urandom_range(1, 50);
      else clock_ms = $urandom;
   endtask

   function automatic logic [3:0] pick_cards();
      if ($urandom_range(0, 1) == 1) return EXPECTED_CARDS;
      return 4'($urandom_range(0, 15));
   endfunction

   // one test: begin, then a run of steps with mostly plausible outcomes; sometimes just noise items
   task automatic run_session();
      int   steps;
      logic op;
      sender_idles = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 19) == 0) begin
         // noise
         repeat ($urandom_range(2, 6))
            send_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      4'($urandom_range(0, 15)));
         return;
      end
      if ($urandom_range(0, 7) == 0) clock_ms = $urandom;
      send_item(OP_BEGIN, clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      steps = $urandom_range(4, 40);
      for (int i = 0; i < steps; i++) begin
         op = ($urandom_range(0, 39) == 0) ? OP_BEGIN : OP_STEP;
         advance_clock();
         send_item(op, clock_ms, $urandom_range(0, 3) != 0, $urandom_range(0, 6) != 0,
                   $urandom_range(0, 4) != 0, pick_cards());
      end
   endtask

   task automatic run_setting(logic [31:0] lim, logic cont, logic [31:0] dly);
      int goal;
      apply_config(lim, cont, dly);
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) run_session();
   endtask

   initial begin
      items_sent   = 0;
      settings_run = 0;
      clock_ms     = 32'd0;
      sender_idles = 1'b1;
      pressure_go     <= 1'b0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_op          <= OP_BEGIN;
      req_now_ms      <= 32'd0;
      req_poll_ok     <= 1'b0;
      req_setup_ok    <= 1'b0;
      req_resolve_ok  <= 1'b0;
      req_cards_found <= 4'd0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_TIMEOUT_LIMIT;
      csr_data        <= 32'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed pass with the reset configuration
      step_at(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 4'd15);      // step while idle
      send_item(OP_BEGIN, 32'd100, 1'b0, 1'b0, 1'b0, 4'd0);
      step_at(32'd100, 1'b0, 1'b1, 1'b1, 4'd1);             // poll fails
      step_at(32'd101, 1'b0, 1'b0, 1'b0, 4'd0);             // retry back to poll
      step_at(32'd102, 1'b1, 1'b0, 1'b0, 4'd0);
      step_at(32'd103, 1'b0, 1'b0, 1'b1, 4'd1);             // setup failure
      step_at(32'd104, 1'b0, 1'b0, 1'b0, 4'd0);
      step_at(32'd105, 1'b1, 1'b0, 1'b0, 4'd0);
      step_at(32'd106, 1'b0, 1'b1, 1'b1, 4'd2);             // wrong card count
      step_at(32'd50, 1'b0, 1'b0, 1'b0, 4'd1);              // no time check here
      step_at(32'd107, 1'b0, 1'b0, 1'b1, 4'd0);             // tries exhausted
      step_at(32'd20000, 1'b0, 1'b0, 1'b0, 4'd0);           // retry times out
      step_at(32'd20001, 1'b0, 1'b0, 1'b0, 4'd0);
      step_at(32'd20002, 1'b0, 1'b0, 1'b0, 4'd0);
      send_item(OP_BEGIN, 32'hFFFF_F000, 1'b1, 1'b1, 1'b1, 4'd15); // end time wraps
      step_at(32'hFFFF_F001, 1'b1, 1'b1, 1'b1, 4'd1);
      send_item(OP_BEGIN, 32'd200, 1'b1, 1'b1, 1'b1, 4'd1);  // restart mid-test
      step_at(32'd201, 1'b1, 1'b0, 1'b0, 4'd0);
      step_at(32'd202, 1'b0, 1'b1, 1'b1, 4'd1);             // detection
      step_at(32'd203, 1'b0, 1'b0, 1'b0, 4'd0);
      send_item(OP_BEGIN, 32'd300, 1'b0, 1'b0, 1'b0, 4'd0);
      step_at(32'd299, 1'b1, 1'b1, 1'b1, 4'd1);             // time before start
      step_at(32'd300, 1'b0, 1'b0, 1'b0, 4'd0);
      step_at(32'd301, 1'b0, 1'b0, 1'b0, 4'd0);

      run_setting(32'd0, 1'b1, 32'd0);
      run_setting(32'd120, 1'b1, 32'd3);
      run_setting(32'd60, 1'b0, 32'd25);
      pressure_go <= 1'b1;
      run_setting(32'hFFFF_FFFF, 1'b1, 32'd10);
      run_setting(32'd1, 1'b1, 32'hFFFF_FFFF);
      run_setting(32'($urandom_range(20, 400)), 1'b1, 32'($urandom_range(10, 80)));
      run_setting(32'd0, 1'b1, 32'd40);
      run_setting(32'd200, 1'b0, 32'd0);

      drain_results();
      repeat (10) @(posedge clock);
      $display("Sent %0d items (%0d not ignored) over %0d register settings.",
               items_sent, live_items, settings_run);
      $display("Checked %0d results: %0d detections, %0d timeouts.",
               results_seen, detections, timeouts);
      if (fail_count == 0)
         $display("card_detect_test_sequencer verification clean");
      else
         $display("card_detect_test_sequencer verification failed");
      $finish;
   end

endmodule

// ===== card_detect_test_sequencer.f =====
+incdir+rtl/core
rtl/core/cdts_pkg.sv
rtl/core/cdts_csr.sv
rtl/core/cdts_step.sv
rtl/core/card_detect_test_sequencer.sv
bench/card_detect_test_sequencer_checker.sv
bench/card_detect_test_sequencer_tb.sv
